// File: sv/crc_framed_packet_parser_assert.svh
// Assertion macros shared by the frame parser modules.
// Included by crcfpp_frame and crcfpp_outq; depends on nothing else.
`ifndef CRC_FRAMED_PACKET_PARSER_ASSERT_SVH
`define CRC_FRAMED_PACKET_PARSER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CRCFPP_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CRCFPP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/crcfpp_pkg.sv
// Types, constants and the CRC-16/CCITT-FALSE byte update for the frame parser.
// Used by crcfpp_frame, crcfpp_outq and crc_framed_packet_parser; no dependencies.
`timescale 1ns / 1ps

package crcfpp_pkg;

    // Frame layout, in byte positions (17 bits to match the byte counter).
    localparam logic [16:0] HDR_BYTES = 17'd8;
    localparam logic [16:0] TS_BYTES  = 17'd4;
    localparam logic [16:0] CRC_BYTES = 17'd2;
    localparam logic [16:0] MIN_FRAME = 17'd14;
    localparam logic [16:0] COUNT_MAX = 17'h1FFFF;

    // CRC-16/CCITT-FALSE constants.
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_TOP  = 16'h8000;

    // Configuration register indexes.
    localparam logic CFG_SYNC_WORD   = 1'b0;
    localparam logic CFG_MAX_PAYLOAD = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [15:0] SYNC_WORD_RESET   = 16'hAA55;
    localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd256;

    // Result kinds.
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    typedef enum logic [2:0] {
        STATUS_OK       = 3'd0,
        STATUS_SHORT    = 3'd1,
        STATUS_BAD_SYNC = 3'd2,
        STATUS_TOO_LONG = 3'd3,
        STATUS_CRC_ERR  = 3'd4
    } status_t;

    // One result transaction as it travels through the output queue.
    typedef struct packed {
        logic        kind;
        logic [7:0]  payload_byte;
        logic [15:0] byte_index;
        logic [7:0]  version;
        logic [7:0]  command;
        logic [15:0] sequence_res;
        logic [15:0] payload_length;
        logic [31:0] timestamp;
        logic [15:0] received_crc;
        status_t     status;
    } result_t;

    // One byte through the MSB-first CRC, unrolled over its eight bits.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0] b);
        logic [15:0] crc;
        crc = crc_in ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if ((crc & CRC_TOP) != 16'h0000)
                crc = {crc[14:0], 1'b0} ^ CRC_POLY;
            else
                crc = {crc[14:0], 1'b0};
        end
        return crc;
    endfunction

endpackage

// File: sv/crcfpp_frame.sv
// Frame state and per-byte parse step: header capture, CRC, payload and verdict.
// Depends on crcfpp_pkg and crc_framed_packet_parser_assert.svh.
`timescale 1ns / 1ps
`include "crc_framed_packet_parser_assert.svh"

module crcfpp_frame (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [7:0]          data_byte,
    input  logic                end_of_buffer,
    input  logic [15:0]         sync_word,
    input  logic [15:0]         max_payload,
    output logic                payload_valid,
    output crcfpp_pkg::result_t payload_res,
    output logic                verdict_valid,
    output crcfpp_pkg::result_t verdict_res
);
    import crcfpp_pkg::*;

    logic [16:0] byte_count_reg, byte_count_next;
    logic [15:0] crc_reg, crc_next;
    logic [15:0] sync_reg, sync_next;
    logic [7:0]  version_reg, version_next;
    logic [7:0]  command_reg, command_next;
    logic [15:0] sequence_reg, sequence_next;
    logic [15:0] length_reg, length_next;
    logic [31:0] timestamp_reg, timestamp_next;
    logic [15:0] rx_crc_reg, rx_crc_next;

    logic [16:0] ts_start;
    logic [16:0] crc_start;
    logic [16:0] frame_end;
    logic [16:0] count_inc;
    logic [15:0] crc_upd;
    logic        in_payload;
    status_t     status;

    // Region boundaries follow from the length captured so far.
    assign ts_start  = HDR_BYTES + {1'b0, length_reg};
    assign crc_start = ts_start + TS_BYTES;
    assign frame_end = crc_start + CRC_BYTES;
    assign crc_upd   = crc_byte(crc_reg, data_byte);
    assign count_inc = (byte_count_reg == COUNT_MAX) ? byte_count_reg
                                                     : byte_count_reg + 17'd1;

    // Field capture and CRC update for the byte at the current position.
    always_comb
    begin
        crc_next       = crc_reg;
        sync_next      = sync_reg;
        version_next   = version_reg;
        command_next   = command_reg;
        sequence_next  = sequence_reg;
        length_next    = length_reg;
        timestamp_next = timestamp_reg;
        rx_crc_next    = rx_crc_reg;
        in_payload     = 1'b0;
        if (byte_count_reg < HDR_BYTES)
        begin
            crc_next = crc_upd;
            unique case (byte_count_reg[2:0]) inside
                3'd0, 3'd1: sync_next     = {sync_reg[7:0], data_byte};
                3'd2:       version_next  = data_byte;
                3'd3:       command_next  = data_byte;
                3'd4, 3'd5: sequence_next = {sequence_reg[7:0], data_byte};
                default:    length_next   = {length_reg[7:0], data_byte};
            endcase
        end
        else if (byte_count_reg < ts_start)
        begin
            crc_next   = crc_upd;
            in_payload = 1'b1;
        end
        else if (byte_count_reg < crc_start)
        begin
            crc_next       = crc_upd;
            timestamp_next = {timestamp_reg[23:0], data_byte};
        end
        else if (byte_count_reg < frame_end)
        begin
            rx_crc_next = {rx_crc_reg[7:0], data_byte};
        end
    end

    // Verdict status, checked in priority order on the updated fields.
    always_comb
    begin
        if (count_inc < MIN_FRAME)
            status = STATUS_SHORT;
        else if (sync_next != sync_word)
            status = STATUS_BAD_SYNC;
        else if (length_next > max_payload)
            status = STATUS_TOO_LONG;
        else if (count_inc < frame_end)
            status = STATUS_SHORT;
        else if (rx_crc_next != crc_next)
            status = STATUS_CRC_ERR;
        else
            status = STATUS_OK;
    end

    // Result transactions produced by this step.
    always_comb
    begin
        payload_valid = step && in_payload && (sync_reg == sync_word)
                        && (length_reg <= max_payload);
        payload_res                = '0;
        payload_res.kind           = KIND_PAYLOAD;
        payload_res.payload_byte   = data_byte;
        payload_res.byte_index     = 16'(byte_count_reg - HDR_BYTES);
        payload_res.status         = STATUS_OK;

        verdict_valid = step && end_of_buffer;
        verdict_res                = '0;
        verdict_res.kind           = KIND_VERDICT;
        verdict_res.version        = version_next;
        verdict_res.command        = command_next;
        verdict_res.sequence_res   = sequence_next;
        verdict_res.payload_length = length_next;
        verdict_res.timestamp      = timestamp_next;
        verdict_res.received_crc   = rx_crc_next;
        verdict_res.status         = status;
    end

    // The frame state returns to reset after the buffer's last byte.
    assign byte_count_next = end_of_buffer ? 17'd0 : count_inc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            crc_reg        <= CRC_INIT;
            sync_reg       <= '0;
            version_reg    <= '0;
            command_reg    <= '0;
            sequence_reg   <= '0;
            length_reg     <= '0;
            timestamp_reg  <= '0;
            rx_crc_reg     <= '0;
        end
        else if (step)
        begin
            byte_count_reg <= byte_count_next;
            if (end_of_buffer)
            begin
                crc_reg       <= CRC_INIT;
                sync_reg      <= '0;
                version_reg   <= '0;
                command_reg   <= '0;
                sequence_reg  <= '0;
                length_reg    <= '0;
                timestamp_reg <= '0;
                rx_crc_reg    <= '0;
            end
            else
            begin
                crc_reg       <= crc_next;
                sync_reg      <= sync_next;
                version_reg   <= version_next;
                command_reg   <= command_next;
                sequence_reg  <= sequence_next;
                length_reg    <= length_next;
                timestamp_reg <= timestamp_next;
                rx_crc_reg    <= rx_crc_next;
            end
        end
    end

    // A verdict leaves the parser ready for a fresh frame.
    `CRCFPP_ASSERT_NEXT(a_verdict_clears, clk, rst_n, verdict_valid, (byte_count_reg == 17'd0) && (crc_reg == CRC_INIT), "frame state not cleared after verdict")
    // Payload bytes come only from past the header.
    `CRCFPP_ASSERT_IMP(a_payload_pos, clk, rst_n, payload_valid, byte_count_reg >= HDR_BYTES, "payload byte emitted inside header")
    // A good verdict needs at least a minimal frame.
    `CRCFPP_ASSERT_IMP(a_ok_len, clk, rst_n, verdict_valid && (status == STATUS_OK), count_inc >= MIN_FRAME, "ok verdict on a short frame")

endmodule

// File: sv/crcfpp_outq.sv
// Result queue: takes up to two result transactions per cycle, hands out one.
// Depends on crcfpp_pkg and crc_framed_packet_parser_assert.svh.
`timescale 1ns / 1ps
`include "crc_framed_packet_parser_assert.svh"

module crcfpp_outq #(
    parameter int DEPTH = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_a,
    input  crcfpp_pkg::result_t data_a,
    input  logic                push_b,
    input  crcfpp_pkg::result_t data_b,
    output logic                space_ok,
    output logic                head_valid,
    output crcfpp_pkg::result_t head,
    input  logic                pop
);
    import crcfpp_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    result_t         mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [PW-1:0]   wr_ptr_b;
    logic [1:0]      push_n;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // Write slot for the second transaction, and pointer/count updates.
    assign push_n      = {1'b0, push_a} + {1'b0, push_b};
    assign wr_ptr_b    = push_a ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
    assign wr_ptr_next = push_b ? ptr_inc(wr_ptr_b)
                                : (push_a ? ptr_inc(wr_ptr_reg) : wr_ptr_reg);
    assign rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
    assign count_next  = count_reg + CW'(push_n) - CW'(pop);

    // Room for the worst case of a payload byte plus a verdict.
    assign space_ok   = (count_reg <= CW'(DEPTH - 2));
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push_a)
            mem_reg[wr_ptr_reg] <= data_a;
        if (push_b)
            mem_reg[wr_ptr_b] <= data_b;
    end

    // Queue control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Pushes never overrun the queue.
    `CRCFPP_ASSERT_IMP(a_no_overrun, clk, rst_n, push_a || push_b, ({1'b0, count_reg} + (CW+1)'(push_n)) <= (CW+1)'(DEPTH), "result queue overrun")
    // Fill level tracks pushes and pops.
    `CRCFPP_ASSERT_NEXT(a_count_track, clk, rst_n, 1'b1, count_reg == $past(count_next), "result queue count mismatch")
    // A waiting head is not moved until it is taken.
    `CRCFPP_ASSERT_NEXT(a_head_hold, clk, rst_n, head_valid && !pop, rd_ptr_reg == $past(rd_ptr_reg), "queue head moved without pop")

endmodule

// File: sv/crc_framed_packet_parser.sv
// Top level of the CRC-16 framed packet parser: config registers, input stage, queue.
// Depends on crcfpp_pkg, crcfpp_frame and crcfpp_outq.
`timescale 1ns / 1ps
//
// Channel   Direction  Handshake             Payload
// config    in         cfg_write             cfg_index, cfg_data
// input     in         in_valid / in_ready   data_byte, end_of_buffer
// result    out        out_valid / out_ready kind ... status (ten fields)
//
// One input byte is parsed per cycle while the result queue has room; a result is
// offered once its byte has passed the input register and then the result queue.
// A last byte that is also a payload byte gives two results, the payload byte first.
// in_ready drops only when the result queue holds fewer than two free entries.
// Reset is asynchronous, active low, and needs no clearing pass.

module crc_framed_packet_parser #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        end_of_buffer,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        kind,
    output logic [7:0]  payload_byte,
    output logic [15:0] byte_index,
    output logic [7:0]  version,
    output logic [7:0]  command,
    output logic [15:0] sequence_res,
    output logic [15:0] payload_length,
    output logic [31:0] timestamp,
    output logic [15:0] received_crc,
    output logic [2:0]  status
);
    import crcfpp_pkg::*;

    logic [15:0] sync_word_reg;
    logic [15:0] max_payload_reg;
    logic        in_valid_reg, in_valid_next;
    logic [7:0]  data_reg;
    logic        last_reg;
    logic        in_accept;
    logic        proc_fire;
    logic        space_ok;
    logic        payload_valid;
    logic        verdict_valid;
    result_t     payload_res;
    result_t     verdict_res;
    result_t     head;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_word_reg   <= SYNC_WORD_RESET;
            max_payload_reg <= MAX_PAYLOAD_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_SYNC_WORD:   sync_word_reg   <= cfg_data;
                CFG_MAX_PAYLOAD: max_payload_reg <= cfg_data;
                default:         sync_word_reg   <= sync_word_reg;
            endcase
        end
    end

    // Input register: refilled in the same cycle its byte is parsed.
    assign proc_fire     = in_valid_reg && space_ok;
    assign in_ready      = !in_valid_reg || proc_fire;
    assign in_accept     = in_valid && in_ready;
    assign in_valid_next = in_accept || (in_valid_reg && !proc_fire);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            data_reg <= data_byte;
            last_reg <= end_of_buffer;
        end
    end

    // Parse step.
    crcfpp_frame u_frame (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (proc_fire),
        .data_byte     (data_reg),
        .end_of_buffer (last_reg),
        .sync_word     (sync_word_reg),
        .max_payload   (max_payload_reg),
        .payload_valid (payload_valid),
        .payload_res   (payload_res),
        .verdict_valid (verdict_valid),
        .verdict_res   (verdict_res)
    );

    // Result queue; a payload byte always goes ahead of the verdict.
    crcfpp_outq #(
        .DEPTH (QUEUE_DEPTH)
    ) u_outq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_a     (payload_valid),
        .data_a     (payload_res),
        .push_b     (verdict_valid),
        .data_b     (verdict_res),
        .space_ok   (space_ok),
        .head_valid (out_valid),
        .head       (head),
        .pop        (out_valid && out_ready)
    );

    // Result fields.
    assign kind           = head.kind;
    assign payload_byte   = head.payload_byte;
    assign byte_index     = head.byte_index;
    assign version        = head.version;
    assign command        = head.command;
    assign sequence_res   = head.sequence_res;
    assign payload_length = head.payload_length;
    assign timestamp      = head.timestamp;
    assign received_crc   = head.received_crc;
    assign status         = 3'(head.status);

endmodule

// File: tb/testbench.sv
// Self-checking testbench for crc_framed_packet_parser: scoreboard class plus drivers.
// Depends on crcfpp_pkg for the result layout, status codes and register indexes.
`timescale 1ns / 1ps

module testbench;

    import crcfpp_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int IDLE_PERCENT  = 22;
    localparam int DRAIN_CYCLES  = 4;
    localparam int REPORT_LIMIT  = 10;
    localparam int HOLD_CYCLES   = 300;
    localparam int SMALL_PAYLOAD = 24;

    // Defects that the random frame builder can inject.
    typedef enum int {
        DEFECT_NONE,
        DEFECT_NOISE,
        DEFECT_SYNC,
        DEFECT_LENGTH,
        DEFECT_CRC,
        DEFECT_TRUNCATE
    } defect_t;

    // Predicts the parser's results byte by byte and checks what comes out.
    class deframer_scoreboard;
        logic [15:0] sync_pattern;
        logic [15:0] payload_limit;
        logic [16:0] pos;
        logic [15:0] crc_acc;
        logic [15:0] sync_seen;
        logic [7:0]  ver_seen;
        logic [7:0]  cmd_seen;
        logic [15:0] seq_seen;
        logic [15:0] len_seen;
        logic [31:0] ts_seen;
        logic [15:0] crc_seen;
        result_t     results_due[$];
        int unsigned failures;
        int unsigned checked;
        int unsigned bytes_in;
        int unsigned buffers;
        int unsigned payload_count;
        int unsigned verdict_tally[5];

        function new();
            sync_pattern  = SYNC_WORD_RESET;
            payload_limit = MAX_PAYLOAD_RESET;
            failures      = 0;
            checked       = 0;
            bytes_in      = 0;
            buffers       = 0;
            payload_count = 0;
            foreach (verdict_tally[i])
                verdict_tally[i] = 0;
            restart_frame();
        endfunction

        // CRC-16/CCITT-FALSE, one data bit at a time, MSB first.
        static function logic [15:0] crc_step(logic [15:0] crc_in, logic [7:0] b);
            logic [15:0] c;
            logic        fb;
            c = crc_in;
            for (int i = 7; i >= 0; i--)
            begin
                fb = c[15] ^ b[i];
                c  = {c[14:0], 1'b0};
                if (fb)
                    c = c ^ CRC_POLY;
            end
            return c;
        endfunction

        function void restart_frame();
            pos       = '0;
            crc_acc   = CRC_INIT;
            sync_seen = '0;
            ver_seen  = '0;
            cmd_seen  = '0;
            seq_seen  = '0;
            len_seen  = '0;
            ts_seen   = '0;
            crc_seen  = '0;
        endfunction

        function void write_reg(logic idx, logic [15:0] val);
            if (idx == CFG_SYNC_WORD)
                sync_pattern = val;
            else if (idx == CFG_MAX_PAYLOAD)
                payload_limit = val;
        endfunction

        function int unsigned pending();
            return results_due.size();
        endfunction

        // Works out the results caused by one accepted byte.
        function void absorb_byte(logic [7:0] b, logic last);
            logic [16:0] ts_start;
            logic [16:0] crc_start;
            logic [16:0] frame_end;
            logic [16:0] offs;
            result_t     r;
            bytes_in++;
            ts_start  = HDR_BYTES + {1'b0, len_seen};
            crc_start = ts_start + TS_BYTES;
            frame_end = crc_start + CRC_BYTES;

            // Header capture, payload delivery, timestamp and trailer by position.
            if (pos < HDR_BYTES)
            begin
                case (pos[2:0])
                    3'd0, 3'd1: sync_seen = {sync_seen[7:0], b};
                    3'd2:       ver_seen  = b;
                    3'd3:       cmd_seen  = b;
                    3'd4, 3'd5: seq_seen  = {seq_seen[7:0], b};
                    default:    len_seen  = {len_seen[7:0], b};
                endcase
                crc_acc = crc_step(crc_acc, b);
            end
            else if (pos < ts_start)
            begin
                crc_acc = crc_step(crc_acc, b);
                if (sync_seen == sync_pattern && len_seen <= payload_limit)
                begin
                    offs           = pos - HDR_BYTES;
                    r              = '0;
                    r.kind         = KIND_PAYLOAD;
                    r.payload_byte = b;
                    r.byte_index   = offs[15:0];
                    r.status       = STATUS_OK;
                    results_due.push_back(r);
                    payload_count++;
                end
            end
            else if (pos < crc_start)
            begin
                ts_seen = {ts_seen[23:0], b};
                crc_acc = crc_step(crc_acc, b);
            end
            else if (pos < frame_end)
            begin
                crc_seen = {crc_seen[7:0], b};
            end

            if (pos < COUNT_MAX)
                pos = pos + 17'd1;

            // The verdict closes the buffer; checks run in a fixed priority order.
            if (last)
            begin
                r                = '0;
                r.kind           = KIND_VERDICT;
                r.version        = ver_seen;
                r.command        = cmd_seen;
                r.sequence_res   = seq_seen;
                r.payload_length = len_seen;
                r.timestamp      = ts_seen;
                r.received_crc   = crc_seen;
                if (pos < MIN_FRAME)
                    r.status = STATUS_SHORT;
                else if (sync_seen != sync_pattern)
                    r.status = STATUS_BAD_SYNC;
                else if (len_seen > payload_limit)
                    r.status = STATUS_TOO_LONG;
                else if (pos < frame_end)
                    r.status = STATUS_SHORT;
                else if (crc_seen != crc_acc)
                    r.status = STATUS_CRC_ERR;
                else
                    r.status = STATUS_OK;
                results_due.push_back(r);
                verdict_tally[int'(r.status)]++;
                buffers++;
                restart_frame();
            end
        endfunction

        function string show(result_t r);
            return $sformatf(
                "kind=%0d byte=%02h idx=%0d ver=%02h cmd=%02h seq=%04h len=%04h ts=%08h crc=%04h st=%0d",
                r.kind, r.payload_byte, r.byte_index, r.version, r.command, r.sequence_res,
                r.payload_length, r.timestamp, r.received_crc, r.status);
        endfunction

        function void flag(string msg);
            failures++;
            if (failures <= REPORT_LIMIT)
                $display("[%0t] MISMATCH: %s", $realtime, msg);
        endfunction

        // Compares one delivered result with the oldest one still due.
        function void check_result(result_t got);
            result_t e;
            string   bad;
            checked++;
            if (results_due.size() == 0)
            begin
                flag($sformatf("result with nothing due: %s", show(got)));
                return;
            end
            e   = results_due.pop_front();
            bad = "";
            if (got.kind !== e.kind)                     bad = {bad, " kind"};
            if (got.payload_byte !== e.payload_byte)     bad = {bad, " payload_byte"};
            if (got.byte_index !== e.byte_index)         bad = {bad, " byte_index"};
            if (got.version !== e.version)               bad = {bad, " version"};
            if (got.command !== e.command)               bad = {bad, " command"};
            if (got.sequence_res !== e.sequence_res)     bad = {bad, " sequence_res"};
            if (got.payload_length !== e.payload_length) bad = {bad, " payload_length"};
            if (got.timestamp !== e.timestamp)           bad = {bad, " timestamp"};
            if (got.received_crc !== e.received_crc)     bad = {bad, " received_crc"};
            if (got.status !== e.status)                 bad = {bad, " status"};
            if (bad != "")
                flag($sformatf("field(s)%s differ\n    expected %s\n    actual   %s",
                               bad, show(e), show(got)));
        endfunction

        function void flag_leftovers();
            if (results_due.size() != 0)
                flag($sformatf("%0d results never arrived, oldest: %s",
                               results_due.size(), show(results_due[0])));
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_write;
    logic        cfg_index;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        end_of_buffer;
    logic        out_valid;
    logic        out_ready;
    logic        kind;
    logic [7:0]  payload_byte;
    logic [15:0] byte_index;
    logic [7:0]  version;
    logic [7:0]  command;
    logic [15:0] sequence_res;
    logic [15:0] payload_length;
    logic [31:0] timestamp;
    logic [15:0] received_crc;
    logic [2:0]  status;

    deframer_scoreboard sb = new();
    logic [7:0]         frame_q[$];
    bit                 steady   = 1'b0;
    int                 hold_len = 0;

    crc_framed_packet_parser DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .end_of_buffer  (end_of_buffer),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .kind           (kind),
        .payload_byte   (payload_byte),
        .byte_index     (byte_index),
        .version        (version),
        .command        (command),
        .sequence_res   (sequence_res),
        .payload_length (payload_length),
        .timestamp      (timestamp),
        .received_crc   (received_crc),
        .status         (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Run limit, counted in clock cycles.
    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Run stopped after %0d cycles with %0d results still due.",
                 cycles, sb.pending());
        $display("crc_framed_packet_parser test failed");
        $finish;
    end

    // Result side: random back-pressure, plus a long hold-off when one is requested.
    initial
    begin : sink
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_len > 0)
            begin
                out_ready <= 1'b0;
                hold_len--;
            end
            else
                out_ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // Samples both handshakes at the clock edge and feeds the scoreboard.
    always @(posedge clk)
    begin : monitor
        result_t got;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.absorb_byte(data_byte, end_of_buffer);
            if (out_valid && out_ready)
            begin
                got.kind           = kind;
                got.payload_byte   = payload_byte;
                got.byte_index     = byte_index;
                got.version        = version;
                got.command        = command;
                got.sequence_res   = sequence_res;
                got.payload_length = payload_length;
                got.timestamp      = timestamp;
                got.received_crc   = received_crc;
                got.status         = status_t'(status);
                sb.check_result(got);
            end
        end
    end

    // Writes both registers on back-to-back cycles.
    task automatic configure(input logic [15:0] sync, input logic [15:0] limit);
        cfg_write <= 1'b1;
        cfg_index <= CFG_SYNC_WORD;
        cfg_data  <= sync;
        @(posedge clk);
        cfg_index <= CFG_MAX_PAYLOAD;
        cfg_data  <= limit;
        @(posedge clk);
        cfg_write <= 1'b0;
        sb.write_reg(CFG_SYNC_WORD, sync);
        sb.write_reg(CFG_MAX_PAYLOAD, limit);
    endtask

    // Fills frame_q with a frame; body may differ from len to build bad frames.
    task automatic make_frame(input logic [15:0] sync, input logic [7:0] ver,
                              input logic [7:0] cmd, input logic [15:0] seq,
                              input logic [15:0] len, input int body,
                              input logic [31:0] ts, input logic [15:0] flip);
        logic [15:0] crc;
        frame_q.delete();
        frame_q.push_back(sync[15:8]);
        frame_q.push_back(sync[7:0]);
        frame_q.push_back(ver);
        frame_q.push_back(cmd);
        frame_q.push_back(seq[15:8]);
        frame_q.push_back(seq[7:0]);
        frame_q.push_back(len[15:8]);
        frame_q.push_back(len[7:0]);
        repeat (body)
            frame_q.push_back(8'($urandom));
        frame_q.push_back(ts[31:24]);
        frame_q.push_back(ts[23:16]);
        frame_q.push_back(ts[15:8]);
        frame_q.push_back(ts[7:0]);
        crc = CRC_INIT;
        foreach (frame_q[i])
            crc = deframer_scoreboard::crc_step(crc, frame_q[i]);
        crc = crc ^ flip;
        frame_q.push_back(crc[15:8]);
        frame_q.push_back(crc[7:0]);
    endtask

    // About half well-formed frames with random content, the rest broken or noise.
    task automatic random_frame(input int max_len);
        defect_t     defect;
        int          roll;
        int          lim;
        int          cap;
        int          span;
        int          body;
        int          cut;
        logic [15:0] sync;
        logic [15:0] len;
        logic [15:0] flip;
        roll = $urandom_range(99);
        if (roll < 8)
            defect = DEFECT_NOISE;
        else if (roll < 18)
            defect = DEFECT_SYNC;
        else if (roll < 28)
            defect = DEFECT_LENGTH;
        else if (roll < 38)
            defect = DEFECT_CRC;
        else if (roll < 50)
            defect = DEFECT_TRUNCATE;
        else
            defect = DEFECT_NONE;

        if (defect == DEFECT_NOISE)
        begin
            frame_q.delete();
            repeat ($urandom_range(30, 1))
                frame_q.push_back(8'($urandom));
            return;
        end

        lim  = int'(sb.payload_limit);
        cap  = (lim < max_len) ? lim : max_len;
        len  = 16'($urandom_range(cap));
        body = int'(len);
        sync = sb.sync_pattern;
        flip = 16'h0000;
        if (defect == DEFECT_SYNC)
            sync = sync ^ 16'($urandom_range(65535, 1));
        if (defect == DEFECT_LENGTH && lim < 65535)
        begin
            span = 65534 - lim;
            if (span > 40)
                span = 40;
            if ($urandom_range(3) == 0)
                len = 16'hFFFF;
            else
                len = 16'(lim + 1 + int'($urandom_range(span)));
            body = $urandom_range(10);
        end
        if (defect == DEFECT_CRC)
            flip = 16'($urandom_range(65535, 1));
        make_frame(sync, 8'($urandom), 8'($urandom), 16'($urandom), len, body,
                   $urandom, flip);

        if (defect == DEFECT_TRUNCATE)
        begin
            cut = $urandom_range(frame_q.size() - 1, 1);
            while (frame_q.size() > cut)
                void'(frame_q.pop_back());
        end
        else if ($urandom_range(9) == 0)
        begin
            // A few bytes past the trailer, which the parser must ignore.
            repeat ($urandom_range(4, 1))
                frame_q.push_back(8'($urandom));
        end
    endtask

    // Offers every byte of frame_q, marking the last one as the buffer's end.
    task automatic send_frame();
        for (int i = 0; i < frame_q.size(); i++)
        begin
            while (!steady && $urandom_range(99) < IDLE_PERCENT)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            in_valid      <= 1'b1;
            data_byte     <= frame_q[i];
            end_of_buffer <= (i == frame_q.size() - 1);
            @(posedge clk);
            while (!in_ready)
                @(posedge clk);
        end
    endtask

    task automatic random_traffic(input int target);
        int sent;
        sent = 0;
        while (sent < target)
        begin
            if ($urandom_range(39) == 0)
                random_frame(300);
            else
                random_frame(SMALL_PAYLOAD);
            send_frame();
            sent += frame_q.size();
        end
    endtask

    // Waits until every predicted result has been delivered, then idles for DRAIN_CYCLES.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    initial
    begin : stimulus
        rst_n         <= 1'b0;
        cfg_write     <= 1'b0;
        cfg_index     <= CFG_SYNC_WORD;
        cfg_data      <= 16'h0000;
        in_valid      <= 1'b0;
        data_byte     <= 8'h00;
        end_of_buffer <= 1'b0;
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: a one-byte payload frame with extreme header values, a lone
        // byte, and a header that claims the largest length but stops there.
        make_frame(sb.sync_pattern, 8'hFF, 8'h00, 16'hFFFF, 16'd1, 1, 32'hFFFF_FFFF, 16'h0000);
        send_frame();
        frame_q = {8'h00};
        send_frame();
        make_frame(sb.sync_pattern, 8'h00, 8'hFF, 16'h0000, 16'hFFFF, 0, 32'h0, 16'h0000);
        while (frame_q.size() > 8)
            void'(frame_q.pop_back());
        send_frame();

        // Reset configuration, then a long payload while the result side holds off.
        random_traffic(350);
        hold_len = HOLD_CYCLES;
        make_frame(sb.sync_pattern, 8'($urandom), 8'($urandom), 16'($urandom), 16'd200, 200,
                   $urandom, 16'h0000);
        send_frame();
        settle();

        // Low extremes of both registers.
        configure(16'h0000, 16'h0000);
        random_traffic(300);
        settle();

        // High extremes, then an empty-payload frame followed by a run of trailing bytes.
        configure(16'hFFFF, 16'hFFFF);
        random_traffic(300);
        make_frame(sb.sync_pattern, 8'($urandom), 8'($urandom), 16'($urandom), 16'd0, 0,
                   $urandom, 16'h0000);
        repeat (20)
            frame_q.push_back(8'($urandom));
        send_frame();
        settle();

        // Random registers; the first stretch runs with no idling on either side.
        configure(16'($urandom), 16'($urandom_range(40, 1)));
        steady = 1'b1;
        random_traffic(200);
        steady = 1'b0;
        random_traffic(150);
        settle();
        repeat (10)
            @(posedge clk);

        sb.flag_leftovers();
        $display("Sent %0d bytes in %0d buffers; %0d results checked, %0d of them payload bytes.",
                 sb.bytes_in, sb.buffers, sb.checked, sb.payload_count);
        $display("Verdicts ok/short/bad sync/too long/crc error: %0d/%0d/%0d/%0d/%0d, %0d failures.",
                 sb.verdict_tally[0], sb.verdict_tally[1], sb.verdict_tally[2],
                 sb.verdict_tally[3], sb.verdict_tally[4], sb.failures);
        if (sb.failures == 0)
            $display("crc_framed_packet_parser test passed");
        else
            $display("crc_framed_packet_parser test failed");
        $finish;
    end

endmodule

// File: crc_framed_packet_parser.f
+incdir+sv
sv/crcfpp_pkg.sv
sv/crcfpp_frame.sv
sv/crcfpp_outq.sv
sv/crc_framed_packet_parser.sv
tb/testbench.sv
